>>> sv/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared codes and the control word broadcast along the ordered list cells.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY_DEF = 16;

  // Commands
  localparam logic [2:0] CMD_APPEND     = 3'd0;
  localparam logic [2:0] CMD_INSERT_AT  = 3'd1;
  localparam logic [2:0] CMD_DELETE_EQ  = 3'd2;
  localparam logic [2:0] CMD_DELETE_AT  = 3'd3;
  localparam logic [2:0] CMD_UPDATE_EQ  = 3'd4;
  localparam logic [2:0] CMD_UPDATE_AT  = 3'd5;
  localparam logic [2:0] CMD_READ_ALL   = 3'd6;

  // Result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Cell operations
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_HOLD  = 3'd0;  // keep own value
  localparam mode_t MODE_INS   = 3'd1;  // open a gap at pos, shift towards tail
  localparam mode_t MODE_DEL   = 3'd2;  // close the gap at pos, shift towards head
  localparam mode_t MODE_SET   = 3'd3;  // write data at pos
  localparam mode_t MODE_SUBST = 3'd4;  // write data where own value equals key
  localparam mode_t MODE_ROT   = 3'd5;  // shift towards head, head re-enters at pos

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  pos;
    logic        keep;   // rotate: head re-enters the list
    logic [31:0] data;
    logic [31:0] key;
  } ctrl_t;

endpackage

>>> sv/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds a single entry and trades it with its neighbours.
// ----------------------------------------------------------------------------
module ole_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  ole_pkg::ctrl_t    ctrl,
  input  logic [31:0]       left,   // neighbour nearer the head
  input  logic [31:0]       right,  // neighbour nearer the tail
  input  logic [31:0]       head,   // value of slot 0
  output logic [31:0]       value
);
  import ole_pkg::*;

  localparam logic [7:0] MY_POS = 8'(INDEX);

  logic [31:0] value_next;

  always_comb begin
    value_next = value;
    case (ctrl.mode)
      MODE_INS: begin
        if (MY_POS == ctrl.pos) value_next = ctrl.data;
        else if (MY_POS > ctrl.pos) value_next = left;
      end
      MODE_DEL: begin
        if (MY_POS >= ctrl.pos) value_next = right;
      end
      MODE_SET: begin
        if (MY_POS == ctrl.pos) value_next = ctrl.data;
      end
      MODE_SUBST: begin
        if (value == ctrl.key) value_next = ctrl.data;
      end
      MODE_ROT: begin
        if (ctrl.keep && MY_POS == ctrl.pos) value_next = head;
        else value_next = right;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> sv/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  command  | start & !busy -> transfer | cmd, position, match_value, replacement
//  result   | done, one cycle           | status, element, last
//
// Append, insert, delete at index and both updates need no sequencer state:
// the cells shift or overwrite in parallel and the status appears the next cycle.
// Delete-all-equal and read-all rotate the row through slot 0, one entry a
// cycle, and visit each of the length entries (at most CAPACITY) once; a
// read gives one result per cycle. busy is high throughout. Reset clears the
// length and the sequencer; entry contents stay undefined. The receiver
// cannot hold off results, so nothing stalls on the result side.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [7:0]  position,
  input  logic [31:0] match_value,
  input  logic [31:0] replacement,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] element,
  output logic        last
);
  import ole_pkg::*;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CAPACITY);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_COMPACT = 2'd1;
  localparam logic [1:0] S_READ    = 2'd2;

  logic [1:0]       state, state_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] remain, remain_next;   // entries not yet visited
  logic [LEN_W-1:0] kept, kept_next;       // entries kept by the compaction
  logic [31:0]      key, key_next;
  logic             done_next, last_next;
  logic [1:0]       status_next;
  logic [31:0]      element_next;
  ctrl_t            ctrl;
  logic [31:0]      vals [CAPACITY];
  logic [7:0]       len8;
  logic             keep_head;

  assign len8      = 8'(len);
  assign busy      = (state != S_IDLE);
  assign keep_head = (vals[0] != key);

  // Row of cells; the end cells see their own value beyond the row.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = vals[g];
    end else begin : g_mid_l
      assign left_v = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_v = vals[g];
    end else begin : g_mid_r
      assign right_v = vals[g+1];
    end
    ole_cell #(.INDEX(g)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_v),
      .right (right_v),
      .head  (vals[0]),
      .value (vals[g])
    );
  end

  always_comb begin
    state_next   = state;
    len_next     = len;
    remain_next  = remain;
    kept_next    = kept;
    key_next     = key;
    done_next    = 1'b0;
    status_next  = ST_OK;
    element_next = 32'd0;
    last_next    = 1'b1;
    ctrl.mode    = MODE_HOLD;
    ctrl.pos     = 8'd0;
    ctrl.keep    = 1'b0;
    ctrl.data    = match_value;
    ctrl.key     = match_value;

    case (state)
      S_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          case (cmd)
            CMD_APPEND, CMD_INSERT_AT: begin
              ctrl.pos = (cmd == CMD_APPEND) ? len8 : position;
              if (ctrl.pos > len8) begin
                status_next = ST_RANGE;
              end else if (len >= LEN_MAX) begin
                status_next = ST_FULL;
              end else begin
                ctrl.mode = MODE_INS;
                len_next  = len + LEN_W'(1);
              end
            end
            CMD_DELETE_EQ: begin
              if (len == '0) begin
                status_next = ST_EMPTY;
              end else begin
                // hold the result until the compaction pass finishes
                done_next   = 1'b0;
                key_next    = match_value;
                remain_next = len;
                kept_next   = '0;
                state_next  = S_COMPACT;
              end
            end
            CMD_DELETE_AT: begin
              ctrl.pos = position;
              if (len == '0) begin
                status_next = ST_EMPTY;
              end else if (position >= len8) begin
                status_next = ST_RANGE;
              end else begin
                ctrl.mode = MODE_DEL;
                len_next  = len - LEN_W'(1);
              end
            end
            CMD_UPDATE_EQ: begin
              // slots beyond the length may change: they are never read
              ctrl.mode = MODE_SUBST;
              ctrl.data = replacement;
            end
            CMD_UPDATE_AT: begin
              ctrl.pos  = position;
              ctrl.data = replacement;
              if (len == '0) begin
                status_next = ST_EMPTY;
              end else if (position >= len8) begin
                status_next = ST_RANGE;
              end else begin
                ctrl.mode = MODE_SET;
              end
            end
            CMD_READ_ALL: begin
              if (len == '0) begin
                status_next = ST_EMPTY;
              end else begin
                done_next   = 1'b0;
                remain_next = len;
                state_next  = S_READ;
              end
            end
            default: status_next = ST_OK;
          endcase
        end
      end

      S_COMPACT: begin
        // advance the head out; a survivor re-enters behind the kept block
        ctrl.mode   = MODE_ROT;
        ctrl.keep   = keep_head;
        ctrl.pos    = 8'(remain) + 8'(kept) - 8'd1;
        remain_next = remain - LEN_W'(1);
        kept_next   = kept + LEN_W'(keep_head);
        if (remain == LEN_W'(1)) begin
          len_next    = kept_next;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      S_READ: begin
        // rotate the whole list once, showing each head in turn
        ctrl.mode    = MODE_ROT;
        ctrl.keep    = 1'b1;
        ctrl.pos     = len8 - 8'd1;
        done_next    = 1'b1;
        element_next = vals[0];
        last_next    = (remain == LEN_W'(1));
        remain_next  = remain - LEN_W'(1);
        if (remain == LEN_W'(1)) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    remain  <= remain_next;
    kept    <= kept_next;
    key     <= key_next;
    status  <= status_next;
    element <= element_next;
    last    <= last_next;
  end

endmodule
